// ----- sv/ttbl_pkg.sv -----
package ttbl_pkg;

    // Default parameter values
    localparam int FRACTION_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF    = 32;

    // Fixed field widths
    localparam int LEVEL_INT_BITS = 32;
    localparam int BURST_W        = 32;
    localparam int CFG_DATA_W     = 48;
    localparam int CFG_INDEX_W    = 3;
    localparam int CMD_W          = 2;
    localparam int LEN_W          = 16;
    localparam int OCTET_SUM_W    = 48;
    localparam int OUT_CNT_W      = 32;

    // Stream widths: slave tdata carries message_length, tuser carries command
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = CMD_W;
    // Master tdata: allowed + six counters = 225 bits, padded to 232
    localparam int M_FIELDS_W = 1 + 4 * OUT_CNT_W + 2 * OCTET_SUM_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MESSAGE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CALL    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MESSAGE_RATE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MESSAGE_BURST = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OCTET_RATE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OCTET_BURST   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CALL_RATE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CALL_BURST    = 3'd5;

    // Per-bucket operation for the current request
    typedef struct packed {
        logic refill;
        logic take;
    } bucket_op_t;

    // Counter update for the current request
    typedef struct packed {
        logic msg_req;
        logic msg_ok;
        logic call_req;
        logic call_ok;
        logic clear;
    } stat_op_t;

endpackage

// ----- sv/ttbl_bucket.sv -----
module ttbl_bucket
    import ttbl_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rate_we,
    input  logic                                  burst_we,
    input  logic [CFG_DATA_W-1:0]                 cfg_data,
    input  bucket_op_t                            op,
    input  logic [LEVEL_INT_BITS+FRACTION_BITS-1:0] need,
    output logic                                  grant
);

    localparam int LEVEL_W = LEVEL_INT_BITS + FRACTION_BITS;

    logic [LEVEL_W-1:0] rate_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;

    logic [LEVEL_W-1:0] cap;
    logic [LEVEL_W-1:0] fill_cap;
    logic [LEVEL_W:0]   sum;
    logic [LEVEL_W-1:0] refilled;
    logic               disabled;
    logic               enough;

    assign cap      = LEVEL_W'(burst_reg) << FRACTION_BITS;
    assign fill_cap = LEVEL_W'(burst_we ? cfg_data[BURST_W-1:0] : burst_reg) << FRACTION_BITS;
    assign sum      = {1'b0, level_reg} + {1'b0, rate_reg};
    assign refilled = (sum > {1'b0, cap}) ? cap : sum[LEVEL_W-1:0];
    assign disabled = (rate_reg == '0) && (burst_reg == '0);
    assign enough   = (level_reg >= need);
    assign grant    = disabled || enough;

    always_comb
    begin
        level_next = level_reg;
        if (rate_we || burst_we)
        begin
            level_next = fill_cap;
        end
        else if (op.refill)
        begin
            level_next = refilled;
        end
        else if (op.take && !disabled && enough)
        begin
            level_next = level_reg - need;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= '0;
            burst_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            if (rate_we)
            begin
                // Register is 48 bits; keep only the level's width of it
                rate_reg <= LEVEL_W'(cfg_data);
            end
            if (burst_we)
            begin
                burst_reg <= cfg_data[BURST_W-1:0];
            end
            level_reg <= level_next;
        end
    end

    // Level never exceeds the bucket capacity
    a_level_capped: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= cap)
        else $error("bucket level above capacity");

    // A granted take on an enabled bucket removes exactly the request
    a_take_exact: assert property (@(posedge clk) disable iff (!rst_n)
        op.take && !op.refill && !disabled && enough && !rate_we && !burst_we
        |=> level_reg == $past(level_reg - need))
        else $error("bucket take did not subtract request");

endmodule

// ----- sv/ttbl_stats.sv -----
module ttbl_stats
    import ttbl_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  stat_op_t               op,
    input  logic [LEN_W-1:0]       length,
    output logic [OUT_CNT_W-1:0]   messages_passed,
    output logic [OUT_CNT_W-1:0]   messages_refused,
    output logic [OCTET_SUM_W-1:0] octets_passed,
    output logic [OCTET_SUM_W-1:0] octets_refused,
    output logic [OUT_CNT_W-1:0]   calls_passed,
    output logic [OUT_CNT_W-1:0]   calls_refused
);

    logic [COUNT_BITS-1:0]  msg_pass_reg;
    logic [COUNT_BITS-1:0]  msg_drop_reg;
    logic [OCTET_SUM_W-1:0] oct_pass_reg;
    logic [OCTET_SUM_W-1:0] oct_drop_reg;
    logic [COUNT_BITS-1:0]  call_pass_reg;
    logic [COUNT_BITS-1:0]  call_drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_pass_reg  <= '0;
            msg_drop_reg  <= '0;
            oct_pass_reg  <= '0;
            oct_drop_reg  <= '0;
            call_pass_reg <= '0;
            call_drop_reg <= '0;
        end
        else if (op.clear)
        begin
            msg_pass_reg  <= '0;
            msg_drop_reg  <= '0;
            oct_pass_reg  <= '0;
            oct_drop_reg  <= '0;
            call_pass_reg <= '0;
            call_drop_reg <= '0;
        end
        else
        begin
            if (op.msg_req)
            begin
                if (op.msg_ok)
                begin
                    msg_pass_reg <= msg_pass_reg + COUNT_BITS'(1);
                    oct_pass_reg <= oct_pass_reg + OCTET_SUM_W'(length);
                end
                else
                begin
                    msg_drop_reg <= msg_drop_reg + COUNT_BITS'(1);
                    oct_drop_reg <= oct_drop_reg + OCTET_SUM_W'(length);
                end
            end
            if (op.call_req)
            begin
                if (op.call_ok)
                begin
                    call_pass_reg <= call_pass_reg + COUNT_BITS'(1);
                end
                else
                begin
                    call_drop_reg <= call_drop_reg + COUNT_BITS'(1);
                end
            end
        end
    end

    assign messages_passed  = OUT_CNT_W'(msg_pass_reg);
    assign messages_refused = OUT_CNT_W'(msg_drop_reg);
    assign octets_passed    = oct_pass_reg;
    assign octets_refused   = oct_drop_reg;
    assign calls_passed     = OUT_CNT_W'(call_pass_reg);
    assign calls_refused    = OUT_CNT_W'(call_drop_reg);

    // Clear leaves every counter at zero
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        op.clear |=> (msg_pass_reg == '0) && (msg_drop_reg == '0) &&
                     (oct_pass_reg == '0) && (oct_drop_reg == '0) &&
                     (call_pass_reg == '0) && (call_drop_reg == '0))
        else $error("counters not cleared");

endmodule

// ----- sv/triple_token_bucket_limiter.sv -----
// Triple token-bucket rate limiter. Three buckets (messages, octets, calls)
// hold levels in unsigned fixed point, 32 integer bits and FRACTION_BITS
// fraction bits. Requests enter on the s_axis stream: tuser is the command
// (tick refill, message request, call request, clear counters) and tdata is
// the message length. Every request produces exactly one result on m_axis:
// the allowed flag plus all six pass/drop counters as they stand after that
// request. A message request tries the message bucket (one token) and the
// octet bucket (length tokens) independently; a bucket that grants keeps its
// deduction even if the other one refuses. A bucket with rate and burst both
// zero always grants and takes nothing. Throughput is one request per clock
// while m_axis_tready is high, passing the input register and then the result
// register, with the bucket adds and compares between them. A result held by
// m_axis_tready low stalls only the stage behind it; the input register still
// takes one more request. Configuration goes in on the cfg channel (index 0..5
// as rate/burst for message, octet, call; other indexes ignored) and must be
// written only while no request is in flight; writing either register of a
// bucket fills that bucket to its burst. cfg_ready is always high.
module triple_token_bucket_limiter
    import ttbl_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,  // [15:0] message_length
    input  logic [S_TUSER_W-1:0]   s_axis_tuser,  // [1:0] command

    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] allowed, [32:1] messages_passed, [64:33] messages_refused,
    // [112:65] octets_passed, [160:113] octets_refused,
    // [192:161] calls_passed, [224:193] calls_refused, [231:225] zero
    output logic [M_TDATA_W-1:0]   m_axis_tdata,

    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LEVEL_W = LEVEL_INT_BITS + FRACTION_BITS;

    // Input register
    logic             in_valid_reg;
    logic [CMD_W-1:0] in_cmd_reg;
    logic [LEN_W-1:0] in_len_reg;

    // Result register
    logic             out_valid_reg;
    logic             allowed_reg;
    logic             allowed_next;

    logic             s_accept;
    logic             advance;
    logic             cfg_write;

    // Config decode
    logic msg_rate_we, msg_burst_we;
    logic oct_rate_we, oct_burst_we;
    logic call_rate_we, call_burst_we;

    // Bucket interface
    bucket_op_t         msg_op, oct_op, call_op;
    logic               msg_grant, oct_grant, call_grant;
    logic [LEVEL_W-1:0] one_token;
    logic [LEVEL_W-1:0] octet_need;

    stat_op_t           stat_op;

    logic [OUT_CNT_W-1:0]   messages_passed, messages_refused;
    logic [OCTET_SUM_W-1:0] octets_passed, octets_refused;
    logic [OUT_CNT_W-1:0]   calls_passed, calls_refused;

    // The request in the input register is resolved when the result slot is
    // free or being drained; bucket and counter state update on that edge,
    // so the next request to resolve already sees the updated state.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_cmd_reg <= s_axis_tuser;
            in_len_reg <= s_axis_tdata[LEN_W-1:0];
        end
    end

    always_comb
    begin
        msg_rate_we   = 1'b0;
        msg_burst_we  = 1'b0;
        oct_rate_we   = 1'b0;
        oct_burst_we  = 1'b0;
        call_rate_we  = 1'b0;
        call_burst_we = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MESSAGE_RATE:  msg_rate_we   = 1'b1;
                REG_MESSAGE_BURST: msg_burst_we  = 1'b1;
                REG_OCTET_RATE:    oct_rate_we   = 1'b1;
                REG_OCTET_BURST:   oct_burst_we  = 1'b1;
                REG_CALL_RATE:     call_rate_we  = 1'b1;
                REG_CALL_BURST:    call_burst_we = 1'b1;
                default:           ; // unused indexes are ignored
            endcase
        end
    end

    // Command decode, gated by advance so nothing moves on a stalled request
    always_comb
    begin
        msg_op  = '0;
        oct_op  = '0;
        call_op = '0;
        stat_op = '0;
        if (advance)
        begin
            unique case (in_cmd_reg)
                CMD_TICK:
                begin
                    msg_op.refill  = 1'b1;
                    oct_op.refill  = 1'b1;
                    call_op.refill = 1'b1;
                end
                CMD_MESSAGE:
                begin
                    msg_op.take     = 1'b1;
                    oct_op.take     = 1'b1;
                    stat_op.msg_req = 1'b1;
                end
                CMD_CALL:
                begin
                    call_op.take     = 1'b1;
                    stat_op.call_req = 1'b1;
                end
                CMD_CLEAR:
                begin
                    stat_op.clear = 1'b1;
                end
            endcase
        end
        stat_op.msg_ok  = msg_grant && oct_grant;
        stat_op.call_ok = call_grant;
    end

    assign one_token  = LEVEL_W'(1) << FRACTION_BITS;
    assign octet_need = LEVEL_W'(in_len_reg) << FRACTION_BITS;

    assign allowed_next = (stat_op.msg_req && stat_op.msg_ok) ||
                          (stat_op.call_req && stat_op.call_ok);

    ttbl_bucket #(.FRACTION_BITS(FRACTION_BITS)) u_msg_bucket
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rate_we  (msg_rate_we),
        .burst_we (msg_burst_we),
        .cfg_data (cfg_data),
        .op       (msg_op),
        .need     (one_token),
        .grant    (msg_grant)
    );

    ttbl_bucket #(.FRACTION_BITS(FRACTION_BITS)) u_oct_bucket
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rate_we  (oct_rate_we),
        .burst_we (oct_burst_we),
        .cfg_data (cfg_data),
        .op       (oct_op),
        .need     (octet_need),
        .grant    (oct_grant)
    );

    ttbl_bucket #(.FRACTION_BITS(FRACTION_BITS)) u_call_bucket
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rate_we  (call_rate_we),
        .burst_we (call_burst_we),
        .cfg_data (cfg_data),
        .op       (call_op),
        .need     (one_token),
        .grant    (call_grant)
    );

    // Counters only move on advance, which needs a free or draining result slot, so while
    // a result waits the counter registers hold exactly its values.
    ttbl_stats #(.COUNT_BITS(COUNT_BITS)) u_stats
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .op               (stat_op),
        .length           (in_len_reg),
        .messages_passed  (messages_passed),
        .messages_refused (messages_refused),
        .octets_passed    (octets_passed),
        .octets_refused   (octets_refused),
        .calls_passed     (calls_passed),
        .calls_refused    (calls_refused)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            allowed_reg <= allowed_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (M_TDATA_W - M_FIELDS_W)'(0),
        calls_refused,
        calls_passed,
        octets_refused,
        octets_passed,
        messages_refused,
        messages_passed,
        allowed_reg
    };

    // An accepted request always lands in the input register
    a_in_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> in_valid_reg)
        else $error("accepted request lost");

    // Tick and clear never report a pass
    a_tick_clear_refused: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ((in_cmd_reg == CMD_TICK) || (in_cmd_reg == CMD_CLEAR))
        |=> m_axis_tvalid && !allowed_reg)
        else $error("tick or clear reported allowed");

endmodule
